// File: hdl/mnop_pkg.sv
// ----------------------------------------------------------------------------
// mnop_pkg
// Shared types and constants for the key-on/key-off note pairing unit.
// ----------------------------------------------------------------------------
package mnop_pkg;

  localparam int unsigned PitchCountDef = 128;
  localparam int unsigned TimeBitsDef   = 32;

  // Stored key-on fields other than the date: velocity, channel, port
  localparam int unsigned KeyFieldBits = 7 + 4 + 8;

  typedef enum logic [1:0] {
    OP_KEY_ON  = 2'd0,
    OP_KEY_OFF = 2'd1,
    OP_PASS    = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  event_type;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [3:0]  channel;
    logic [7:0]  port;
    logic [31:0] date;
  } in_t;

  typedef struct packed {
    logic        is_note;
    logic [7:0]  out_type;
    logic [6:0]  out_pitch;
    logic [6:0]  out_velocity;
    logic [3:0]  out_channel;
    logic [7:0]  out_port;
    logic [31:0] out_date;
    logic [31:0] duration;
  } out_t;

  // Table access for one transfer
  typedef struct packed {
    logic rd;   // fetch entry for a key-off
    logic wr;   // store key-on fields and mark valid
    logic clr;  // drop the entry after a matched key-off
  } tbl_req_t;

endpackage

// File: hdl/mnop_key_table.sv
// ----------------------------------------------------------------------------
// mnop_key_table
// Per-pitch store of held keys: flop valid bits and a synchronous data memory.
// ----------------------------------------------------------------------------
module mnop_key_table #(
  parameter int unsigned PITCH_COUNT = mnop_pkg::PitchCountDef,
  parameter int unsigned TIME_BITS   = mnop_pkg::TimeBitsDef,
  localparam int unsigned IdxW   = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1,
  localparam int unsigned EntryW = mnop_pkg::KeyFieldBits + TIME_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mnop_pkg::tbl_req_t   req_i,
  input  logic [IdxW-1:0]      idx_i,
  input  logic [EntryW-1:0]    wdata_i,
  output logic                 valid_o,
  output logic [EntryW-1:0]    rdata_o
);

  logic [PITCH_COUNT-1:0] valid_q;
  logic [PITCH_COUNT-1:0] valid_d;
  logic [EntryW-1:0]      mem_q [PITCH_COUNT];
  logic [EntryW-1:0]      rdata_q;

  // Callers only hand in indexes below PITCH_COUNT when acting on them
  assign valid_o = valid_q[idx_i];
  assign rdata_o = rdata_q;

  always_comb begin
    valid_d = valid_q;
    if (req_i.wr) begin
      valid_d[idx_i] = 1'b1;
    end else if (req_i.clr) begin
      valid_d[idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[idx_i] <= wdata_i;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[idx_i];
    end
  end

endmodule

// File: hdl/midi_note_on_off_pairing_unit.sv
// ----------------------------------------------------------------------------
// midi_note_on_off_pairing_unit
// Pairs key-on and key-off events by pitch into notes with a duration.
// ----------------------------------------------------------------------------
// Output: a result passes stage 1 and the output register, then shows on the
//   result ports for one cycle, marked by strobe_o; the receiver cannot stall.
// Throughput: one transfer per cycle while busy is low; a key-on writes the
//   single-port pitch table, a matched key-off reads its entry and clears it.
// Reset: asynchronous, active low; all held keys are dropped at once. busy is
//   high during reset and for the first cycle after it, then stays low.
module midi_note_on_off_pairing_unit #(
  parameter int unsigned PITCH_COUNT = mnop_pkg::PitchCountDef,
  parameter int unsigned TIME_BITS   = mnop_pkg::TimeBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mnop_pkg::in_t  item_i,
  output logic           strobe_o,
  output mnop_pkg::out_t result_o
);

  localparam int unsigned IdxW   = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;
  localparam int unsigned EntryW = mnop_pkg::KeyFieldBits + TIME_BITS;
  // Wide enough for both the port date and the internal time stamp
  localparam int unsigned WideW  = (TIME_BITS > 32) ? TIME_BITS : 32;

  // ---------------------------------------------------------------------------
  // Transfer decode
  // ---------------------------------------------------------------------------
  logic                take;
  logic                is_on;
  logic                is_off;
  logic                in_range;
  logic                hit;
  logic [IdxW-1:0]     idx;
  logic [WideW-1:0]    date_wide;
  logic [TIME_BITS-1:0] date_t;
  logic [EntryW-1:0]   wdata;
  logic                tbl_valid;
  logic [EntryW-1:0]   tbl_rdata;
  mnop_pkg::tbl_req_t  tbl_req;

  logic busy_q;

  assign busy = busy_q;
  assign take = start && !busy_q;

  always_comb begin
    is_on  = 1'b0;
    is_off = 1'b0;
    unique case (item_i.operation)
      mnop_pkg::OP_KEY_ON:  is_on  = 1'b1;
      mnop_pkg::OP_KEY_OFF: is_off = 1'b1;
      default: ;  // everything else passes through
    endcase
  end

  assign in_range  = {1'b0, item_i.pitch} < 8'(PITCH_COUNT);
  assign idx       = IdxW'(item_i.pitch);
  assign hit       = in_range && tbl_valid;

  // Fit the port date to the internal time width (truncate or zero-extend)
  assign date_wide = WideW'(item_i.date);
  assign date_t    = date_wide[TIME_BITS-1:0];
  assign wdata     = {item_i.velocity, item_i.channel, item_i.port, date_t};

  // Key-on stores; a matched key-off fetches the entry and drops it. Both
  // touch the table in the transfer cycle, so the next transfer already sees
  // the updated entry and no forwarding is needed.
  assign tbl_req.wr  = take && is_on && in_range;
  assign tbl_req.rd  = take && is_off && hit;
  assign tbl_req.clr = take && is_off && hit;

  mnop_key_table #(
    .PITCH_COUNT (PITCH_COUNT),
    .TIME_BITS   (TIME_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .idx_i   (idx),
    .wdata_i (wdata),
    .valid_o (tbl_valid),
    .rdata_o (tbl_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: wait for the table read, form the result
  // ---------------------------------------------------------------------------
  logic           s1_vld_q;
  logic           s1_vld_d;
  logic           s1_note_q;
  mnop_pkg::in_t  s1_item_q;
  logic [TIME_BITS-1:0] s1_date_q;

  // A result follows a matched key-off, or passes through any other code
  assign s1_vld_d = take && ((is_off && hit) || (!is_on && !is_off));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      s1_vld_q <= 1'b0;
    end else begin
      busy_q   <= 1'b0;
      s1_vld_q <= s1_vld_d;
    end
  end

  // Hold payload only when a result follows
  always_ff @(posedge clk_i) begin
    if (s1_vld_d) begin
      s1_note_q <= is_off;
      s1_item_q <= item_i;
      s1_date_q <= date_t;
    end
  end

  logic [6:0]           rd_vel;
  logic [3:0]           rd_chan;
  logic [7:0]           rd_port;
  logic [TIME_BITS-1:0] rd_date;
  logic [TIME_BITS-1:0] dur_t;
  logic [WideW-1:0]     on_date_wide;
  logic [WideW-1:0]     dur_wide;
  mnop_pkg::out_t       result_d;

  assign {rd_vel, rd_chan, rd_port, rd_date} = tbl_rdata;
  assign dur_t        = s1_date_q - rd_date;  // wraps modulo 2^TIME_BITS
  assign on_date_wide = WideW'(rd_date);
  assign dur_wide     = WideW'(dur_t);

  always_comb begin
    if (s1_note_q) begin
      result_d.is_note      = 1'b1;
      result_d.out_type     = '0;
      result_d.out_pitch    = s1_item_q.pitch;
      result_d.out_velocity = rd_vel;
      result_d.out_channel  = rd_chan;
      result_d.out_port     = rd_port;
      result_d.out_date     = on_date_wide[31:0];
      result_d.duration     = dur_wide[31:0];
    end else begin
      result_d.is_note      = 1'b0;
      result_d.out_type     = s1_item_q.event_type;
      result_d.out_pitch    = s1_item_q.pitch;
      result_d.out_velocity = s1_item_q.velocity;
      result_d.out_channel  = s1_item_q.channel;
      result_d.out_port     = s1_item_q.port;
      result_d.out_date     = s1_item_q.date;
      result_d.duration     = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: one strobe per result
  // ---------------------------------------------------------------------------
  logic           strobe_q;
  mnop_pkg::out_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      result_q <= result_d;
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

// File: hdl/mnop_checker.sv
// ----------------------------------------------------------------------------
// mnop_checker
// Port-level checks on the note pairing unit, bound to its top level.
// ----------------------------------------------------------------------------
module mnop_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input mnop_pkg::in_t  item_i,
  input logic           strobe_o,
  input mnop_pkg::out_t result_o
);

  logic take;
  logic is_key;

  assign take   = start && !busy;
  assign is_key = (item_i.operation == mnop_pkg::OP_KEY_ON) ||
                  (item_i.operation == mnop_pkg::OP_KEY_OFF);

  // Pass-through transfers always yield a result that is not a note
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !is_key) |=> ##1 (strobe_o && !result_o.is_note))
    else $error("pass-through transfer lost");

  // Key-on never yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.operation == mnop_pkg::OP_KEY_ON) |=> ##1 !strobe_o)
    else $error("result after key-on");

  // No transfer, no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> ##1 !strobe_o)
    else $error("result without transfer");

  // Pass-through results carry no duration; notes carry no type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.is_note ? (result_o.out_type == '0)
                                   : (result_o.duration == '0)))
    else $error("result fields inconsistent with kind");

endmodule

bind midi_note_on_off_pairing_unit mnop_checker u_mnop_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .strobe_o (strobe_o),
  .result_o (result_o)
);
